// ===== design/vln_pkg.sv =====
// shared constants and types for the vector length and normalize block
package vln_pkg;

  localparam int COMP_W     = 16;
  localparam int UNIT_FRAC  = 14;
  localparam int LANES      = 3;
  localparam int LEN_FRAC   = 8;
  localparam int MAG_W      = COMP_W;
  localparam int SQ_W       = 2 * COMP_W;
  localparam int N_W        = SQ_W + 2 * LEN_FRAC;
  localparam int LEN_W      = N_W / 2;
  localparam int REM_W      = LEN_W + 3;
  localparam int SQ_STAGES  = LEN_W;
  localparam int UNIT_W     = UNIT_FRAC + 2;
  localparam int DIV_STAGES = UNIT_FRAC + 1;
  localparam int DIV_PRE    = UNIT_FRAC + LEN_FRAC - DIV_STAGES;

  localparam logic [DIV_STAGES-1:0] QUO_LIMIT = DIV_STAGES'(1) << UNIT_FRAC;

  typedef struct packed {
    logic [SQ_W-1:0]             sq;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][MAG_W-1:0] mag;
  } side_t;

  typedef struct packed {
    logic                          zero;
    logic [LANES-1:0][UNIT_W-1:0]  unit;
    logic [LEN_W-1:0]              len;
    logic [SQ_W-1:0]               sq;
  } res_t;

endpackage

// ===== design/vln_sqrt.sv =====
// pipelined digit-by-digit square root, one root bit per stage
module vln_sqrt import vln_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [LEN_W-1:0] root_o,
  output side_t            side_o
);

  logic [SQ_STAGES-1:0] v_q;
  logic [REM_W-1:0]     rem_q  [SQ_STAGES];
  logic [LEN_W-1:0]     root_q [SQ_STAGES];
  logic [N_W-1:0]       n_q    [SQ_STAGES];
  side_t                side_q [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in, rem_t, trial;
    logic [LEN_W-1:0] root_in;
    logic [N_W-1:0]   n_in;
    side_t            side_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = {side_i.sq, {(2 * LEN_FRAC){1'b0}}};
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign n_in    = n_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next two bits and try root*4+1
    assign rem_t = {rem_in[REM_W-3:0], n_in[N_W-1 -: 2]};
    assign trial = REM_W'({root_in, 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_t >= trial) begin
          rem_q[k]  <= rem_t - trial;
          root_q[k] <= {root_in[LEN_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_t;
          root_q[k] <= {root_in[LEN_W-2:0], 1'b0};
        end
        n_q[k]    <= {n_in[N_W-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[SQ_STAGES-1];
  assign root_o  = root_q[SQ_STAGES-1];
  assign side_o  = side_q[SQ_STAGES-1];

endmodule

// ===== design/vln_div_lane.sv =====
// pipelined restoring divider for one component, one quotient bit per stage
module vln_div_lane import vln_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [MAG_W-1:0]      mag_i,
  input  logic [LEN_W-1:0]      len_i,
  output logic                  valid_o,
  output logic [DIV_STAGES-1:0] quo_o
);

  logic [DIV_STAGES-1:0] v_q;
  logic [LEN_W-1:0]      r_q   [DIV_STAGES];
  logic [LEN_W-1:0]      len_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] quo_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic                  v_in;
    logic [LEN_W-1:0]      r_in, d_in;
    logic [DIV_STAGES-1:0] q_in;
    logic [LEN_W:0]        r_t;

    if (k == 0) begin : g_first
      // high dividend bits are below the divisor, so they start as remainder
      assign v_in = valid_i;
      assign r_in = LEN_W'(mag_i) << DIV_PRE;
      assign d_in = len_i;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
      assign d_in = len_q[k-1];
      assign q_in = quo_q[k-1];
    end

    assign r_t = {r_in, 1'b0};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (r_t >= {1'b0, d_in}) begin
          r_q[k]   <= LEN_W'(r_t - {1'b0, d_in});
          quo_q[k] <= {q_in[DIV_STAGES-2:0], 1'b1};
        end else begin
          r_q[k]   <= LEN_W'(r_t);
          quo_q[k] <= {q_in[DIV_STAGES-2:0], 1'b0};
        end
        len_q[k] <= d_in;
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign quo_o   = quo_q[DIV_STAGES-1];

endmodule

// ===== design/vln_out_buf.sv =====
// two-entry output buffer that decouples the pipeline from the result side
module vln_out_buf import vln_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  res_t  data_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  data_o,
  output logic [1:0] count_o
);

  res_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/vector_length_normalize_top.sv =====
// top level: squares, sum, square root, per-lane divide and output buffer
//
//  channel   dir  tdata (low bit up)                         tuser
//  s_axis    in   x_in[15:0] y_in[31:16] z_in[47:32]         -
//  m_axis    out  sq_norm length_q8 unit_x unit_y unit_z     zero_vector
//
// one item per cycle sustained while the output buffer is not full
// the path runs through the 24-stage root pipeline and the 15-stage divide lanes
// a full output buffer stalls the whole pipeline; tready is a register decode
// reset clears only valid bits and the buffer pointers and count
module vector_length_normalize_top import vln_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [47:0]   s_axis_tdata_i,   // x_in, y_in, z_in
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [103:0]  m_axis_tdata_o,   // sq_norm, length_q8, unit_x, unit_y, unit_z
  output logic          m_axis_tuser_o    // zero_vector
);

  logic adv, full;
  logic v0_q, v1_q, v2_q;
  logic [LANES-1:0][COMP_W-1:0]  comp_q;
  logic [LANES-1:0][MAG_W-1:0]   mag1_q;
  logic [LANES-1:0]              neg1_q;
  logic [LANES-1:0][SQ_W-1:0]    sqr_q;
  side_t side2_q;

  assign adv             = ~full;
  assign s_axis_tready_o = ~full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic             neg;
    logic [MAG_W-1:0] mag;
    assign neg = comp_q[l][COMP_W-1];
    assign mag = neg ? MAG_W'(-comp_q[l]) : MAG_W'(comp_q[l]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        comp_q[l] <= s_axis_tdata_i[l*COMP_W +: COMP_W];
        mag1_q[l] <= mag;
        neg1_q[l] <= neg;
        sqr_q[l]  <= mag * mag;
      end
    end
  end

  // merge the lane squares
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q.sq  <= sqr_q[0] + sqr_q[1] + sqr_q[2];
      side2_q.neg <= neg1_q;
      side2_q.mag <= mag1_q;
    end
  end

  logic             sv;
  logic [LEN_W-1:0] root;
  side_t            sside;

  vln_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .side_i  (side2_q),
    .valid_o (sv),
    .root_o  (root),
    .side_o  (sside)
  );

  logic [LANES-1:0]                 dv;
  logic [LANES-1:0][DIV_STAGES-1:0] quo;

  for (genvar l = 0; l < LANES; l++) begin : g_div
    vln_div_lane u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sv),
      .mag_i   (sside.mag[l]),
      .len_i   (root),
      .valid_o (dv[l]),
      .quo_o   (quo[l])
    );
  end

  // sideband delay matching the divide lanes
  side_t            dside_q [DIV_STAGES];
  logic [LEN_W-1:0] dlen_q  [DIV_STAGES];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dside_q[0] <= sside;
      dlen_q[0]  <= root;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dside_q[k] <= dside_q[k-1];
        dlen_q[k]  <= dlen_q[k-1];
      end
    end
  end

  res_t  res;
  side_t fside;
  assign fside = dside_q[DIV_STAGES-1];

  always_comb begin
    logic [DIV_STAGES-1:0] qc;
    res.sq   = fside.sq;
    res.len  = dlen_q[DIV_STAGES-1];
    res.zero = (fside.sq == '0);
    for (int l = 0; l < LANES; l++) begin
      qc = (quo[l] > QUO_LIMIT) ? QUO_LIMIT : quo[l];
      if (res.zero) begin
        res.unit[l] = '0;
      end else if (fside.neg[l]) begin
        res.unit[l] = -UNIT_W'(qc);
      end else begin
        res.unit[l] = UNIT_W'(qc);
      end
    end
  end

  res_t       ob;
  logic [1:0] ob_cnt;

  vln_out_buf u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (adv && dv[0]),
    .data_i  (res),
    .full_o  (full),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (ob),
    .count_o (ob_cnt)
  );

  assign m_axis_tdata_o = {ob.unit[2], ob.unit[1], ob.unit[0], ob.len, ob.sq};
  assign m_axis_tuser_o = ob.zero;

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv[0] == dv[1] && dv[1] == dv[2])
    else $error("divide lanes out of step");

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_cnt != 2'd3)
    else $error("output buffer overflow");

  a_stall_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("stalled with nothing to deliver");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (ob.len == '0 && ob.unit[0] == '0 && ob.unit[1] == '0 && ob.unit[2] == '0))
    else $error("zero vector with nonzero length or unit");

endmodule
